// ===== rtl/core/first_fit_allocator_with_eviction_macros.svh =====
// assertion helpers for the allocator, sampled on clk, off while in reset
`ifndef FIRST_FIT_ALLOCATOR_WITH_EVICTION_MACROS_SVH
`define FIRST_FIT_ALLOCATOR_WITH_EVICTION_MACROS_SVH

// same-cycle implication
`define FFA_CHECK_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define FFA_CHECK_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/core/ffa_pkg.sv =====
`default_nettype none
package ffa_pkg;

  // request codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // result status codes
  localparam logic [2:0] ST_FREE_RUN   = 3'd0;
  localparam logic [2:0] ST_FIT_EVICT  = 3'd1;
  localparam logic [2:0] ST_LAST_EVICT = 3'd2;
  localparam logic [2:0] ST_NO_ROOM    = 3'd3;
  localparam logic [2:0] ST_FREED      = 3'd4;

  // controller states
  typedef enum logic [4:0] {
    S_IDLE, S_START, S_RUN, S_TAKE, S_INS, S_INS_WR, S_TS_RD, S_TS_CHK,
    S_LAST_RD, S_LAST_CHK, S_REL_RD, S_REL_CHK, S_DEL_RD, S_DEL_CHK,
    S_SH_RD, S_SH_WR, S_REL_END, S_DONE
  } state_t;

  // datapath commands
  typedef enum logic [4:0] {
    C_NONE, C_LOAD, C_NOROOM, C_RUN_STEP, C_RUN_HIT, C_TAKE_STEP, C_INS_START,
    C_INS_RD, C_INS_WR, C_INS_PUT, C_TS_START, C_TAB_RD_ENT, C_ENT_INC,
    C_FIT_HIT, C_TAB_RD_LAST, C_LAST_HIT, C_OWN_RD, C_REL_CHK, C_DEL_START,
    C_SH_RD, C_SH_WR, C_DEC, C_TAKE_START, C_FREED, C_EMIT
  } dp_cmd_t;

  // datapath status flags
  typedef struct packed {
    logic is_free;
    logic n_zero;
    logic idx_end;
    logic run_hit;
    logic take_more;
    logic ins_block;
    logic ins_more;
    logic ent_end;
    logic fit;
    logic tot_zero;
    logic last_fit;
    logic del_match;
    logic sh_more;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/ffa_if.sv =====
`default_nettype none
// request channel
interface ffa_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] owner_id;
  logic [6:0] req_words;
  modport source (output valid, op, owner_id, req_words, input ready);
  modport sink (input valid, op, owner_id, req_words, output ready);
endinterface

// result channel
interface ffa_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [5:0] base_word;
  logic [7:0] evicted_owner;
  logic       evicted_valid;
  modport source (output valid, status, base_word, evicted_owner, evicted_valid,
                  input ready);
  modport sink (input valid, status, base_word, evicted_owner, evicted_valid,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ffa_ctrl.sv =====
`default_nettype none
module ffa_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire ffa_pkg::dp_stat_t st,
  output ffa_pkg::dp_cmd_t      cmd
);

  ffa_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffa_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = ffa_pkg::C_NONE;
    in_ready  = 1'b0;
    case (state_r)
      ffa_pkg::S_IDLE: begin
        // no request beat is taken while in reset
        in_ready = rst_n;
        if (in_valid) begin
          cmd       = ffa_pkg::C_LOAD;
          state_nxt = ffa_pkg::S_START;
        end
      end
      ffa_pkg::S_START: begin
        if (st.is_free) begin
          state_nxt = ffa_pkg::S_REL_RD;
        end else if (st.n_zero) begin
          cmd       = ffa_pkg::C_NOROOM;
          state_nxt = ffa_pkg::S_DONE;
        end else begin
          state_nxt = ffa_pkg::S_RUN;
        end
      end
      // first-fit scan over the free map
      ffa_pkg::S_RUN: begin
        if (st.idx_end) begin
          cmd       = ffa_pkg::C_TS_START;
          state_nxt = ffa_pkg::S_TS_RD;
        end else if (st.run_hit) begin
          cmd       = ffa_pkg::C_RUN_HIT;
          state_nxt = ffa_pkg::S_TAKE;
        end else begin
          cmd = ffa_pkg::C_RUN_STEP;
        end
      end
      ffa_pkg::S_TAKE: begin
        if (st.take_more) begin
          cmd = ffa_pkg::C_TAKE_STEP;
        end else begin
          cmd       = ffa_pkg::C_INS_START;
          state_nxt = ffa_pkg::S_INS;
        end
      end
      // table insert, shifting upward one entry at a time
      ffa_pkg::S_INS: begin
        if (st.ins_block) begin
          state_nxt = ffa_pkg::S_DONE;
        end else if (st.ins_more) begin
          cmd       = ffa_pkg::C_INS_RD;
          state_nxt = ffa_pkg::S_INS_WR;
        end else begin
          cmd       = ffa_pkg::C_INS_PUT;
          state_nxt = ffa_pkg::S_DONE;
        end
      end
      ffa_pkg::S_INS_WR: begin
        cmd       = ffa_pkg::C_INS_WR;
        state_nxt = ffa_pkg::S_INS;
      end
      // search for a fitting victim
      ffa_pkg::S_TS_RD: begin
        if (st.ent_end) begin
          state_nxt = ffa_pkg::S_LAST_RD;
        end else begin
          cmd       = ffa_pkg::C_TAB_RD_ENT;
          state_nxt = ffa_pkg::S_TS_CHK;
        end
      end
      ffa_pkg::S_TS_CHK: begin
        if (st.fit) begin
          cmd       = ffa_pkg::C_FIT_HIT;
          state_nxt = ffa_pkg::S_REL_RD;
        end else begin
          cmd       = ffa_pkg::C_ENT_INC;
          state_nxt = ffa_pkg::S_TS_RD;
        end
      end
      ffa_pkg::S_LAST_RD: begin
        if (st.tot_zero) begin
          cmd       = ffa_pkg::C_NOROOM;
          state_nxt = ffa_pkg::S_DONE;
        end else begin
          cmd       = ffa_pkg::C_TAB_RD_LAST;
          state_nxt = ffa_pkg::S_LAST_CHK;
        end
      end
      ffa_pkg::S_LAST_CHK: begin
        if (st.last_fit) begin
          cmd       = ffa_pkg::C_LAST_HIT;
          state_nxt = ffa_pkg::S_REL_RD;
        end else begin
          cmd       = ffa_pkg::C_NOROOM;
          state_nxt = ffa_pkg::S_DONE;
        end
      end
      // release sweep over all words
      ffa_pkg::S_REL_RD: begin
        if (st.idx_end) begin
          cmd       = ffa_pkg::C_DEL_START;
          state_nxt = ffa_pkg::S_DEL_RD;
        end else begin
          cmd       = ffa_pkg::C_OWN_RD;
          state_nxt = ffa_pkg::S_REL_CHK;
        end
      end
      ffa_pkg::S_REL_CHK: begin
        cmd       = ffa_pkg::C_REL_CHK;
        state_nxt = ffa_pkg::S_REL_RD;
      end
      // delete first table entry of the owner
      ffa_pkg::S_DEL_RD: begin
        if (st.ent_end) begin
          state_nxt = ffa_pkg::S_REL_END;
        end else begin
          cmd       = ffa_pkg::C_TAB_RD_ENT;
          state_nxt = ffa_pkg::S_DEL_CHK;
        end
      end
      ffa_pkg::S_DEL_CHK: begin
        if (st.del_match) begin
          state_nxt = ffa_pkg::S_SH_RD;
        end else begin
          cmd       = ffa_pkg::C_ENT_INC;
          state_nxt = ffa_pkg::S_DEL_RD;
        end
      end
      ffa_pkg::S_SH_RD: begin
        if (st.sh_more) begin
          cmd       = ffa_pkg::C_SH_RD;
          state_nxt = ffa_pkg::S_SH_WR;
        end else begin
          cmd       = ffa_pkg::C_DEC;
          state_nxt = ffa_pkg::S_REL_END;
        end
      end
      ffa_pkg::S_SH_WR: begin
        cmd       = ffa_pkg::C_SH_WR;
        state_nxt = ffa_pkg::S_SH_RD;
      end
      ffa_pkg::S_REL_END: begin
        if (st.is_free) begin
          cmd       = ffa_pkg::C_FREED;
          state_nxt = ffa_pkg::S_DONE;
        end else begin
          cmd       = ffa_pkg::C_TAKE_START;
          state_nxt = ffa_pkg::S_TAKE;
        end
      end
      ffa_pkg::S_DONE: begin
        if (st.out_free) begin
          cmd       = ffa_pkg::C_EMIT;
          state_nxt = ffa_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ffa_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/ffa_dp.sv =====
`default_nettype none
module ffa_dp #(
  parameter int MemWords     = 64,
  parameter int TableEntries = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ffa_pkg::dp_cmd_t cmd,
  output ffa_pkg::dp_stat_t     st,
  input  wire logic             in_op,
  input  wire logic [7:0]       in_owner_id,
  input  wire logic [6:0]       in_req_words,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output logic [2:0]            out_status,
  output logic [5:0]            out_base_word,
  output logic [7:0]            out_evicted_owner,
  output logic                  out_evicted_valid
);

  localparam int AW = $clog2(MemWords);
  localparam int CW = $clog2(MemWords + 1);
  localparam int EW = $clog2(TableEntries);
  localparam int TW = $clog2(TableEntries + 1);
  localparam int DW = ((CW > 7) ? CW : 7) + 1;

  typedef struct packed {
    logic [7:0]    owner;
    logic [AW-1:0] start;
    logic [6:0]    len;
  } ent_t;

  // storage
  logic [MemWords-1:0] free_r;
  logic [7:0]          own_mem [MemWords];
  logic [7:0]          own_q_r;
  ent_t                tab_mem [TableEntries];
  ent_t                tab_q_r;
  logic [TW-1:0]       total_r;

  // request context
  logic          op_r;
  logic [7:0]    id_r;
  logic [6:0]    n_r;
  logic [7:0]    key_r;
  logic [CW-1:0] idx_r;
  logic [CW-1:0] run_r;
  logic [TW-1:0] ent_r;
  logic [TW-1:0] pos_r;
  logic [AW-1:0] start_r;
  logic [7:0]    victim_r;
  logic [2:0]    status_r;
  logic          evict_r;

  // result register
  logic       out_valid_r;
  logic [2:0] out_status_r;
  logic [5:0] out_start_r;
  logic [7:0] out_victim_r;
  logic       out_evict_r;

  logic [AW-1:0] widx;
  logic [DW-1:0] hit_start;
  logic [TW-1:0] tab_raddr;
  logic          tab_rd;

  assign widx      = idx_r[AW-1:0];
  assign hit_start = DW'(idx_r) + DW'(1) - DW'(n_r);

  // status flags
  always_comb begin
    st.is_free   = (op_r == ffa_pkg::OP_FREE);
    st.n_zero    = (n_r == '0);
    st.idx_end   = (idx_r == CW'(MemWords));
    st.run_hit   = free_r[widx] && ((DW'(run_r) + DW'(1)) == DW'(n_r));
    st.take_more = (idx_r < CW'(MemWords)) &&
                   (DW'(idx_r) < (DW'(start_r) + DW'(n_r)));
    st.ins_block = (total_r >= TW'(TableEntries)) || (pos_r > total_r);
    st.ins_more  = (ent_r > pos_r);
    st.ent_end   = (ent_r >= total_r);
    st.fit       = (tab_q_r.len >= n_r);
    st.tot_zero  = (total_r == '0);
    st.last_fit  = ((DW'(MemWords) - DW'(tab_q_r.start)) >= DW'(n_r));
    st.del_match = (tab_q_r.owner == key_r);
    st.sh_more   = ((TW + 1)'(ent_r) + (TW + 1)'(1)) < (TW + 1)'(total_r);
    st.out_free  = !out_valid_r || out_ready;
  end

  // table read address
  always_comb begin
    tab_rd    = 1'b1;
    tab_raddr = ent_r;
    case (cmd)
      ffa_pkg::C_TAB_RD_ENT:  tab_raddr = ent_r;
      ffa_pkg::C_TAB_RD_LAST: tab_raddr = total_r - TW'(1);
      ffa_pkg::C_INS_RD:      tab_raddr = ent_r - TW'(1);
      ffa_pkg::C_SH_RD:       tab_raddr = ent_r + TW'(1);
      default:                tab_rd    = 1'b0;
    endcase
  end

  // table memory
  always_ff @(posedge clk) begin
    if (tab_rd) begin
      tab_q_r <= tab_mem[tab_raddr[EW-1:0]];
    end
    case (cmd)
      ffa_pkg::C_INS_WR, ffa_pkg::C_SH_WR: begin
        tab_mem[ent_r[EW-1:0]] <= tab_q_r;
      end
      ffa_pkg::C_INS_PUT: begin
        tab_mem[pos_r[EW-1:0]] <= '{owner: id_r, start: start_r, len: n_r};
      end
      default: begin
      end
    endcase
  end

  // word owner memory
  always_ff @(posedge clk) begin
    if (cmd == ffa_pkg::C_TAKE_STEP) begin
      own_mem[widx] <= id_r;
    end
    if (cmd == ffa_pkg::C_OWN_RD) begin
      own_q_r <= own_mem[widx];
    end
  end

  // free map, entry count and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r      <= '1;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd)
        ffa_pkg::C_TAKE_STEP: free_r[widx] <= 1'b0;
        ffa_pkg::C_REL_CHK: begin
          if (!free_r[widx] && (own_q_r == key_r)) begin
            free_r[widx] <= 1'b1;
          end
        end
        ffa_pkg::C_INS_PUT: total_r     <= total_r + TW'(1);
        ffa_pkg::C_DEC:     total_r     <= total_r - TW'(1);
        ffa_pkg::C_EMIT:    out_valid_r <= 1'b1;
        default: begin
        end
      endcase
    end
  end

  // request context and counters
  always_ff @(posedge clk) begin
    case (cmd)
      ffa_pkg::C_LOAD: begin
        op_r     <= in_op;
        id_r     <= in_owner_id;
        key_r    <= in_owner_id;
        n_r      <= in_req_words;
        idx_r    <= '0;
        run_r    <= '0;
        start_r  <= '0;
        victim_r <= '0;
        evict_r  <= 1'b0;
        status_r <= ffa_pkg::ST_NO_ROOM;
      end
      ffa_pkg::C_NOROOM: status_r <= ffa_pkg::ST_NO_ROOM;
      ffa_pkg::C_RUN_STEP: begin
        run_r <= free_r[widx] ? run_r + CW'(1) : '0;
        idx_r <= idx_r + CW'(1);
      end
      ffa_pkg::C_RUN_HIT: begin
        start_r  <= AW'(hit_start);
        idx_r    <= CW'(hit_start);
        pos_r    <= total_r;
        status_r <= ffa_pkg::ST_FREE_RUN;
      end
      ffa_pkg::C_TAKE_STEP, ffa_pkg::C_REL_CHK: idx_r <= idx_r + CW'(1);
      ffa_pkg::C_INS_START:  ent_r <= total_r;
      ffa_pkg::C_INS_WR:     ent_r <= ent_r - TW'(1);
      ffa_pkg::C_TS_START,
      ffa_pkg::C_DEL_START:  ent_r <= '0;
      ffa_pkg::C_ENT_INC,
      ffa_pkg::C_SH_WR:      ent_r <= ent_r + TW'(1);
      ffa_pkg::C_FIT_HIT: begin
        victim_r <= tab_q_r.owner;
        key_r    <= tab_q_r.owner;
        start_r  <= tab_q_r.start;
        pos_r    <= ent_r;
        status_r <= ffa_pkg::ST_FIT_EVICT;
        evict_r  <= 1'b1;
        idx_r    <= '0;
      end
      ffa_pkg::C_LAST_HIT: begin
        victim_r <= tab_q_r.owner;
        key_r    <= tab_q_r.owner;
        start_r  <= tab_q_r.start;
        pos_r    <= total_r - TW'(1);
        status_r <= ffa_pkg::ST_LAST_EVICT;
        evict_r  <= 1'b1;
        idx_r    <= '0;
      end
      ffa_pkg::C_TAKE_START: idx_r    <= CW'(start_r);
      ffa_pkg::C_FREED:      status_r <= ffa_pkg::ST_FREED;
      ffa_pkg::C_EMIT: begin
        out_status_r <= status_r;
        out_start_r  <= 6'(start_r);
        out_victim_r <= victim_r;
        out_evict_r  <= evict_r;
      end
      default: begin
      end
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_base_word     = out_start_r;
  assign out_evicted_owner = out_victim_r;
  assign out_evicted_valid = out_evict_r;

endmodule
`default_nettype wire

// ===== rtl/core/first_fit_allocator_with_eviction.sv =====
// channel   dir  handshake      beat contents
// in_ch     in   valid/ready    op, owner_id, req_words
// out_ch    out  valid/ready    status, base_word, evicted_owner, evicted_valid
//
// one request at a time; how long a free takes from accept to result is set by
// the word release sweep and the table delete shift. an allocate placed in a free
// run scans the free map, marks its words and inserts a table entry; on eviction,
// the table scan, a full release sweep and the delete precede the marking.
// synchronous active-low reset marks every word free, empties the table, holds off input.
// a waiting result does not block the next request beat; only its finish waits.
`default_nettype none
`include "first_fit_allocator_with_eviction_macros.svh"
module first_fit_allocator_with_eviction #(
  parameter int MemWords     = 64,
  parameter int TableEntries = 32
) (
  input wire logic   clk,
  input wire logic   rst_n,
  ffa_in_if.sink     in_ch,
  ffa_out_if.source  out_ch
);

  ffa_pkg::dp_cmd_t  cmd;
  ffa_pkg::dp_stat_t st;
  logic              in_ready;
  logic              out_evict_st;
  logic              out_unplaced;
  logic              out_clean;

  assign in_ch.ready = in_ready;

  // sequencer
  ffa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // storage and arithmetic
  ffa_dp #(
    .MemWords     (MemWords),
    .TableEntries (TableEntries)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .st                (st),
    .in_op             (in_ch.op),
    .in_owner_id       (in_ch.owner_id),
    .in_req_words      (in_ch.req_words),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_status        (out_ch.status),
    .out_base_word     (out_ch.base_word),
    .out_evicted_owner (out_ch.evicted_owner),
    .out_evicted_valid (out_ch.evicted_valid)
  );

  // result classes for the checks
  assign out_evict_st = (out_ch.status == ffa_pkg::ST_FIT_EVICT) ||
                        (out_ch.status == ffa_pkg::ST_LAST_EVICT);
  assign out_unplaced = (out_ch.status == ffa_pkg::ST_NO_ROOM) ||
                        (out_ch.status == ffa_pkg::ST_FREED);
  assign out_clean    = (out_ch.base_word == 6'd0) && !out_ch.evicted_valid;

  // checks
  `FFA_CHECK_NEXT(a_busy_after_accept, in_ch.valid && in_ready, !in_ready, "accepted while busy")
  `FFA_CHECK_NOW(a_evict_flag, out_ch.valid && out_evict_st, out_ch.evicted_valid, "evict no flag")
  `FFA_CHECK_NOW(a_unplaced_clean, out_ch.valid && out_unplaced, out_clean, "unplaced has data")

endmodule
`default_nettype wire
